FILE: design/row_softmax_macros.svh
// Assertion macros shared by the row softmax design.
`ifndef ROW_SOFTMAX_MACROS_SVH
`define ROW_SOFTMAX_MACROS_SVH
// Implication check, sampled on the rising clock, disabled during reset.
`define RS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check.
`define RS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/rs_pkg.sv
// ----------------------------------------------------------------------------
// rs_pkg
// Types and constants shared by the row softmax modules.
// ----------------------------------------------------------------------------
package rs_pkg;

	typedef struct packed {
		logic signed [15:0] logit;
		logic               row_last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] prob;
		logic        out_last;
	} out_item_t;

	// Row descriptor handed from the front to the back.
	typedef struct packed {
		logic [6:0]         count;
		logic signed [15:0] maxv;
		logic               bank;
	} row_desc_t;

	localparam logic [16:0] LOG2E_Q15 = 17'd47274;

	function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35733;
			5'd15: v = 17'd34218;
			5'd16: v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/rs_ram.sv
// ----------------------------------------------------------------------------
// rs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: design/rs_front.sv
// ----------------------------------------------------------------------------
// rs_front
// Accepts logits, writes them to the active bank and tracks the row maximum.
// ----------------------------------------------------------------------------
module rs_front #(
	parameter int ROW_MAX = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rs_pkg::in_item_t    in_item,
	output logic                in_stall,
	output logic                wr_en,
	output logic [$clog2(ROW_MAX)-1:0] wr_addr,
	output logic                wr_bank,
	output logic [15:0]         wr_data,
	output logic                desc_valid,
	output rs_pkg::row_desc_t   desc,
	input  logic                desc_full
);
	localparam int AW = $clog2(ROW_MAX);
	logic [6:0]         count_q;
	logic signed [15:0] max_q;
	logic               bank_q;
	logic               acc;
	logic               room;
	logic signed [15:0] new_max;

	assign in_stall = desc_full;
	assign acc      = in_valid && !in_stall;
	assign room     = count_q < 7'(ROW_MAX);
	assign new_max  = (room && in_item.logit > max_q) ? in_item.logit : max_q;

	assign wr_en   = acc && room;
	assign wr_addr = count_q[AW-1:0];
	assign wr_bank = bank_q;
	assign wr_data = in_item.logit;

	assign desc_valid = acc && in_item.row_last;
	assign desc.count = room ? count_q + 7'd1 : count_q;
	assign desc.maxv  = new_max;
	assign desc.bank  = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= 16'sh8000;
			bank_q  <= 1'b0;
		end else if (acc) begin
			if (in_item.row_last) begin
				count_q <= '0;
				max_q   <= 16'sh8000;
				bank_q  <= !bank_q;
			end else begin
				count_q <= desc.count;
				max_q   <= new_max;
			end
		end
	end
endmodule

FILE: design/rs_divider.sv
// ----------------------------------------------------------------------------
// rs_divider
// Restoring divider, one quotient bit per cycle, for the rounded probability.
// ----------------------------------------------------------------------------
module rs_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [22:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [32:0] quotient
);
	logic [5:0]  cnt_q;
	logic [32:0] quo_q;
	logic [23:0] rem_q;
	logic [22:0] div_q;
	logic [23:0] trial;
	logic        fit;

	assign trial    = {rem_q[22:0], quo_q[32]};
	assign fit      = trial >= {1'b0, div_q};
	assign busy     = cnt_q != 6'd0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= cnt_q == 6'd1;
			if (start) begin
				cnt_q <= 6'd33;
			end else if (busy) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy) begin
			rem_q <= fit ? trial - {1'b0, div_q} : trial;
			quo_q <= {quo_q[31:0], fit};
		end
	end
endmodule

FILE: design/rs_back.sv
// ----------------------------------------------------------------------------
// rs_back
// Reads back one stored row, computes exponentials and their sum, then
// divides each exponential by the sum and emits the probabilities.
// ----------------------------------------------------------------------------
module rs_back #(
	parameter int ROW_MAX = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                desc_valid,
	input  rs_pkg::row_desc_t   desc,
	output logic                desc_pop,
	output logic                rd_bank,
	output logic [$clog2(ROW_MAX)-1:0] rd_addr,
	input  logic [15:0]         rd_data,
	output logic                out_valid,
	output rs_pkg::out_item_t   out_item,
	input  logic                out_stall
);
	localparam int AW = $clog2(ROW_MAX);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SUM   = 7'b0000010,
		ST_EXP   = 7'b0000100,
		ST_DSTRT = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_WAIT  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [6:0]         idx_q;
	logic               pass2_q;
	logic [22:0]        sum_q;
	logic [16:0]        e_s2;
	logic [16:0]        u_s1;
	logic               rd_pend_s1;
	logic               u_v_s1;
	logic               ex_v_s2;
	logic [33:0]        prod;
	logic [16:0]        u_next;
	logic [15:0]        t;
	logic [8:0]         n;
	logic [3:0]         fi;
	logic [3:0]         fr;
	logic [16:0]        hi;
	logic [16:0]        lo;
	logic [21:0]        dm;
	logic [16:0]        m;
	logic [16:0]        e_next;
	logic               dstart;
	logic               dbusy;
	logic               ddone;
	logic [32:0]        quot;
	logic               out_v_q;
	rs_pkg::out_item_t  out_q;

	// Stage 1: scale the distance to base two.
	assign t      = desc.maxv - rd_data;
	assign prod   = {18'd0, t} * {17'd0, rs_pkg::LOG2E_Q15};
	assign u_next = 17'((prod + 34'd16384) >> 15);
	// Stage 2: table interpolation and shift.
	assign n  = u_s1[16:8];
	assign fi = u_s1[7:4];
	assign fr = u_s1[3:0];
	assign hi = rs_pkg::pow2_tab({1'b0, fi});
	assign lo = rs_pkg::pow2_tab({1'b0, fi} + 5'd1);
	assign dm = ({5'd0, hi - lo} * {18'd0, fr} + 22'd8) >> 4;
	assign m  = hi - dm[16:0];
	assign e_next = (n >= 9'd17) ? 17'd0 : (m >> n[4:0]);

	assign rd_bank  = desc.bank;
	assign rd_addr  = idx_q[AW-1:0];
	assign desc_pop = state_q == ST_WAIT && out_v_q == 1'b0 && !pass2_q;
	assign dstart   = state_q == ST_DSTRT;

	rs_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.dividend({e_s2, 16'd0} + {10'd0, sum_q[22:1]}),
		.divisor(sum_q), .busy(dbusy), .done(ddone), .quotient(quot)
	);

	assign out_valid = out_v_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			pass2_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
			u_v_s1     <= 1'b0;
			ex_v_s2    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			rd_pend_s1 <= 1'b0;
			u_v_s1     <= rd_pend_s1;
			ex_v_s2    <= u_v_s1;
			if (out_v_q && !out_stall && state_q != ST_OUT) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (desc_valid) begin
						idx_q   <= '0;
						pass2_q <= 1'b0;
						state_q <= ST_SUM;
					end
				end
				// Pass one streams every entry through the exp pipeline.
				ST_SUM: begin
					if (idx_q == desc.count) begin
						if (!rd_pend_s1 && !u_v_s1 && !ex_v_s2) begin
							idx_q   <= '0;
							pass2_q <= 1'b1;
							state_q <= ST_EXP;
						end
					end else begin
						rd_pend_s1 <= 1'b1;
						idx_q      <= idx_q + 7'd1;
					end
				end
				// Pass two recomputes one exponential at a time.
				ST_EXP: begin
					if (ex_v_s2) begin
						state_q <= ST_DSTRT;
					end else if (!rd_pend_s1 && !u_v_s1) begin
						rd_pend_s1 <= 1'b1;
					end
				end
				ST_DSTRT: state_q <= ST_DIV;
				ST_DIV: begin
					if (ddone && !dbusy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_v_q || !out_stall) begin
						out_v_q           <= 1'b1;
						out_q.prob        <= (sum_q == '0) ? 16'd0 :
							((quot > 33'd65535) ? 16'hFFFF : quot[15:0]);
						out_q.out_last    <= (idx_q + 7'd1) == desc.count;
						if ((idx_q + 7'd1) == desc.count) begin
							pass2_q <= 1'b0;
							state_q <= ST_WAIT;
						end else begin
							idx_q   <= idx_q + 7'd1;
							state_q <= ST_EXP;
						end
					end
				end
				// The row is released only once its last result has left.
				ST_WAIT: begin
					if (!out_v_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		u_s1 <= u_next;
		e_s2 <= e_next;
		if (state_q == ST_IDLE) begin
			sum_q <= '0;
		end else if (ex_v_s2 && !pass2_q) begin
			sum_q <= sum_q + {6'd0, e_s2};
		end
	end
endmodule

FILE: design/row_softmax.sv
// ----------------------------------------------------------------------------
// row_softmax
// Softmax over one row of Q8.8 logits with the row maximum subtracted.
// ----------------------------------------------------------------------------
// Logits enter one item per cycle while in_stall is low and are written to
// one of two row banks that alternate from row to row; a one-deep row queue
// links the front to the back. After a row's last item the back reads the
// row twice: one pass builds the exponential sum, then each probability is
// recomputed and divided by the sum in the bit-serial 33-bit divider. The
// queue entry is held while the back works on its row, so input stalls from
// the acceptance of a row's last item until that row's last probability has
// been taken. Elements beyond ROW_MAX in a row are dropped.
module row_softmax #(
	parameter int ROW_MAX = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rs_pkg::in_item_t    in_item,
	output logic                in_stall,
	output logic                out_valid,
	output rs_pkg::out_item_t   out_item,
	input  logic                out_stall
);
	`include "row_softmax_macros.svh"
	localparam int AW = $clog2(ROW_MAX);

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              wr_bank;
	logic [15:0]       wr_data;
	logic              push;
	rs_pkg::row_desc_t push_desc;
	logic              pop;
	logic              q_full_q;
	rs_pkg::row_desc_t q_desc_q;
	logic              rd_bank;
	logic [AW-1:0]     rd_addr;
	logic [15:0]       rd0;
	logic [15:0]       rd1;
	logic              rd_bank_s1;

	rs_front #(.ROW_MAX(ROW_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_item(in_item),
		.in_stall(in_stall), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_bank(wr_bank), .wr_data(wr_data), .desc_valid(push),
		.desc(push_desc), .desc_full(q_full_q)
	);

	rs_ram #(.WIDTH(16), .DEPTH(ROW_MAX)) u_bank0 (
		.clk(clk), .we(wr_en && !wr_bank), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rd0)
	);
	rs_ram #(.WIDTH(16), .DEPTH(ROW_MAX)) u_bank1 (
		.clk(clk), .we(wr_en && wr_bank), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_full_q <= 1'b0;
		end else if (push) begin
			q_full_q <= 1'b1;
		end else if (pop) begin
			q_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_bank_s1 <= rd_bank;
		if (push) begin
			q_desc_q <= push_desc;
		end
	end

	rs_back #(.ROW_MAX(ROW_MAX)) u_back (
		.clk(clk), .arst_n(arst_n), .desc_valid(q_full_q), .desc(q_desc_q),
		.desc_pop(pop), .rd_bank(rd_bank), .rd_addr(rd_addr),
		.rd_data(rd_bank_s1 ? rd1 : rd0), .out_valid(out_valid),
		.out_item(out_item), .out_stall(out_stall)
	);

	`RS_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !q_full_q, "row queue overrun")
	`RS_ASSERT_IMP(a_pop_needs_row, clk, arst_n, pop, q_full_q, "pop of empty row queue")
	`RS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for row_softmax: rows of logits are driven with random
// gaps, probabilities are predicted per row and compared in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int ROW_LEN_MAX = 64;

	// Expected probabilities for every row handed to the block.
	class prob_board;
		rs_pkg::out_item_t probs_due[$];
		logic signed [15:0] row_vals[$];
		logic signed [15:0] peak;
		int errors;
		int checked;

		function new();
			peak = -16'sd32768;
			errors = 0;
			checked = 0;
		endfunction

		task report_bad(string what);
			errors++;
			$display("tb: mismatch at %0t: %s", $time, what);
		endtask

		function automatic logic [16:0] exp_neg(logic [15:0] t);
			logic [31:0] u;
			logic [8:0] n;
			logic [3:0] i, r;
			logic [31:0] hi, lo, m;
			u = (32'(t) * 32'd47274 + 32'd16384) >> 15;
			n = u[16:8];
			i = u[7:4];
			r = u[3:0];
			hi = 32'(pow_tab(5'(i)));
			lo = 32'(pow_tab(5'(i) + 5'd1));
			m = hi - (((hi - lo) * 32'(r) + 32'd8) >> 4);
			if (n >= 9'd17)
				return 17'd0;
			return 17'(m >> n);
		endfunction

		function automatic logic [16:0] pow_tab(logic [4:0] k);
			logic [16:0] tab [0:16];
			tab = '{17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
				17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
				17'd38968, 17'd37316, 17'd35733, 17'd34218, 17'd32768};
			return tab[k];
		endfunction

		function void note_logit(rs_pkg::in_item_t it);
			logic [16:0] e [$];
			logic [31:0] total;
			logic [63:0] p;
			rs_pkg::out_item_t o;
			if (row_vals.size() < ROW_LEN_MAX) begin
				row_vals.push_back(it.logit);
				if (it.logit > peak)
					peak = it.logit;
			end
			if (!it.row_last)
				return;
			total = 0;
			foreach (row_vals[k]) begin
				e.push_back(exp_neg(16'(32'(peak) - 32'(row_vals[k]))));
				total += 32'(e[k]);
			end
			foreach (e[k]) begin
				p = 0;
				if (total != 0) begin
					p = ((64'(e[k]) << 16) + 64'(total / 2)) / 64'(total);
					if (p > 64'd65535)
						p = 64'd65535;
				end
				o.prob = p[15:0];
				o.out_last = (k == e.size() - 1);
				probs_due.push_back(o);
			end
			row_vals.delete();
			peak = -16'sd32768;
		endfunction

		task check_prob(rs_pkg::out_item_t got);
			rs_pkg::out_item_t want;
			checked++;
			if (probs_due.size() == 0) begin
				report_bad($sformatf("unexpected probability %0d", got.prob));
				return;
			end
			want = probs_due.pop_front();
			if (got.prob !== want.prob)
				report_bad($sformatf("prob %0d, want %0d", got.prob, want.prob));
			if (got.out_last !== want.out_last)
				report_bad($sformatf("out_last %0b, want %0b", got.out_last,
					want.out_last));
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	rs_pkg::in_item_t in_item;
	rs_pkg::out_item_t out_item;
	prob_board board;
	int rows_sent, logits_sent;
	bit long_hold;

	row_softmax #(.ROW_MAX(ROW_LEN_MAX)) dut (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Offers one logit and holds it until taken; random gaps between bursts.
	task automatic send_logit(logic signed [15:0] v, logic lst);
		in_valid <= 1'b1;
		in_item <= '{logit: v, row_last: lst};
		do @(posedge clk); while (in_stall);
		board.note_logit(in_item);
		logits_sent++;
		if (lst)
			rows_sent++;
		@(negedge clk);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic send_row(int len, int mode);
		logic signed [15:0] v;
		int base;
		base = $urandom_range(0, 65535) - 32768;
		for (int k = 0; k < len; k++) begin
			case (mode)
				0: v = 16'($urandom);
				1: v = 16'(base + $urandom_range(0, 2047) - 1024);
				default: v = 16'(base);
			endcase
			send_logit(v, k == len - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.probs_due.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: random stall pattern, plus one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 9) < 3) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_prob(out_item);

	initial begin
		#40000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		board = new();
		rows_sent = 0;
		logits_sent = 0;
		long_hold = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows: single elements at the extremes and at zero, widest spread,
		// equal values, falling values, and a row longer than the store.
		send_logit(16'sh7fff, 1'b1);
		send_logit(-16'sd32768, 1'b1);
		send_logit(16'sd0, 1'b1);
		send_logit(-16'sd32768, 1'b0);
		send_logit(16'sh7fff, 1'b1);
		send_logit(16'sd256, 1'b0);
		send_logit(16'sd256, 1'b0);
		send_logit(16'sd256, 1'b1);
		send_logit(16'sd0, 1'b0);
		send_logit(-16'sd1, 1'b0);
		send_logit(-16'sd300, 1'b0);
		send_logit(-16'sd4096, 1'b1);
		send_row(ROW_LEN_MAX + 3, 0);
		drain();

		// Long receiver hold-off while rows keep coming, so input stalls.
		long_hold = 1'b1;
		for (int k = 0; k < 4; k++)
			send_row($urandom_range(2, 6), 1);
		drain();

		while (logits_sent < 400) begin
			case ($urandom_range(0, 9))
				0: send_row(ROW_LEN_MAX, $urandom_range(0, 1));
				1: send_row($urandom_range(1, 3), 2);
				2, 3: send_row($urandom_range(1, 8), 0);
				default: send_row($urandom_range(1, 10), 1);
			endcase
			if ($urandom_range(0, 15) == 0)
				drain();
		end
		drain();
		repeat (200) @(negedge clk);

		if (board.probs_due.size() != 0)
			board.report_bad($sformatf("%0d probabilities never arrived",
				board.probs_due.size()));
		$display("tb: %0d rows, %0d logits sent, %0d probabilities checked",
			rows_sent, logits_sent, board.checked);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
